// File: rtl/core/shcdf_pkg.sv
// ----------------------------------------------------------------------------
// shcdf_pkg
// Types, constants and the byte-wide CRC-32 update for the framed receiver.
// ----------------------------------------------------------------------------
package shcdf_pkg;

   localparam int PAYLOAD_LEN_DEF = 100;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
   localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   typedef enum logic [1:0] {
      SYNC_HUNT,
      SYNC_WAIT_H2,
      SYNC_BODY
   } sync_state_type;

   // reflected CRC-32, one byte, eight bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'h0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/core/sync_header_crc32_deframer_top.sv
// ----------------------------------------------------------------------------
// sync_header_crc32_deframer_top
// Framed byte receiver: sync hunt on 0xAA 0x55, sequence, payload, CRC-32.
//
// Input channel req_*: one received byte per item. Output channel rsp_*: one
// item for every byte after the sync header, carrying the byte and its frame
// position; the final CRC byte also carries last, frame_ok and the sequence
// number, and every item carries the saturating bad-frame count. Header
// bytes give no item. An accepted byte passes through two registers, input
// and result, before it shows on rsp_*. Throughput: one byte per cycle while
// rsp_ready stays high, set by the byte-wide CRC update and framing logic.
// When the receiver stalls, the result register holds and the input register
// keeps one more byte; req_ready drops only when both are full. Reset
// (synchronous) empties both registers and returns to hunting for the
// first header byte with the CRC at all ones and the bad count at zero.
// ----------------------------------------------------------------------------
module sync_header_crc32_deframer_top
   import shcdf_pkg::*;
#(
   parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic [6:0]  rsp_byte_index,
   output logic        rsp_last,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_seq_number,
   output logic [15:0] rsp_bad_count
);

   localparam int DATA_END  = 4 + PAYLOAD_LEN;
   localparam int FRAME_END = 8 + PAYLOAD_LEN;
   localparam int CNT_W     = ($clog2(FRAME_END) > 7) ? $clog2(FRAME_END) : 7;

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   sync_state_type    sync_ff, sync_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       crc_ff, crc_in;
   logic [15:0]       seq_ff, seq_in;
   logic [31:0]       recv_ff, recv_in;
   logic [15:0]       bad_ff, bad_in;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff;
   logic [6:0]        rsp_index_ff;
   logic              rsp_last_ff;
   logic              rsp_ok_ff;
   logic [15:0]       rsp_seq_ff;
   logic [15:0]       rsp_bad_ff;

   logic              fire;
   logic              emit;
   logic              last_in;
   logic              ok_in;
   logic [15:0]       seq_out_in;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      sync_in    = sync_ff;
      cnt_in     = cnt_ff;
      crc_in     = crc_ff;
      seq_in     = seq_ff;
      recv_in    = recv_ff;
      bad_in     = bad_ff;
      emit       = 1'b0;
      last_in    = 1'b0;
      ok_in      = 1'b0;
      seq_out_in = 16'h0;
      if (fire) begin
         case (sync_ff)
            SYNC_HUNT: begin
               if (in_byte_ff == SYNC_FIRST) begin
                  crc_in  = crc_byte(CRC_ONES, SYNC_FIRST);
                  cnt_in  = CNT_W'(1);
                  sync_in = SYNC_WAIT_H2;
               end
            end
            SYNC_WAIT_H2: begin
               if (in_byte_ff == SYNC_SECOND) begin
                  crc_in  = crc_byte(crc_ff, in_byte_ff);
                  cnt_in  = CNT_W'(2);
                  sync_in = SYNC_BODY;
               end else if (in_byte_ff == SYNC_FIRST) begin
                  crc_in  = crc_byte(CRC_ONES, SYNC_FIRST);
                  cnt_in  = CNT_W'(1);
                  sync_in = SYNC_WAIT_H2;
               end else begin
                  crc_in  = CRC_ONES;
                  cnt_in  = '0;
                  sync_in = SYNC_HUNT;
               end
            end
            SYNC_BODY: begin
               emit = 1'b1;
               if (cnt_ff < CNT_W'(DATA_END)) begin
                  crc_in = crc_byte(crc_ff, in_byte_ff);
               end
               if (cnt_ff == CNT_W'(2)) begin
                  seq_in = {seq_ff[15:8], in_byte_ff};
               end else if (cnt_ff == CNT_W'(3)) begin
                  seq_in = {in_byte_ff, seq_ff[7:0]};
               end else if (cnt_ff >= CNT_W'(DATA_END)) begin
                  recv_in = {in_byte_ff, recv_ff[31:8]};
               end
               if (cnt_ff == CNT_W'(FRAME_END - 1)) begin
                  last_in    = 1'b1;
                  ok_in      = (recv_in == ~crc_in);
                  seq_out_in = seq_in;
                  if (!ok_in && bad_ff != COUNT_MAX) begin
                     bad_in = bad_ff + 16'd1;
                  end
                  sync_in = SYNC_HUNT;
                  cnt_in  = '0;
                  crc_in  = CRC_ONES;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            default: begin
               sync_in = SYNC_HUNT;
               cnt_in  = '0;
               crc_in  = CRC_ONES;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sync_ff      <= SYNC_HUNT;
         cnt_ff       <= '0;
         crc_ff       <= CRC_ONES;
         seq_ff       <= 16'h0;
         recv_ff      <= 32'h0;
         bad_ff       <= 16'h0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         sync_ff <= sync_in;
         cnt_ff  <= cnt_in;
         crc_ff  <= crc_in;
         seq_ff  <= seq_in;
         recv_ff <= recv_in;
         bad_ff  <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (fire && emit) begin
         rsp_data_ff  <= in_byte_ff;
         rsp_index_ff <= cnt_ff[6:0];
         rsp_last_ff  <= last_in;
         rsp_ok_ff    <= ok_in;
         rsp_seq_ff   <= seq_out_in;
         rsp_bad_ff   <= bad_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_frame_ok   = rsp_ok_ff;
   assign rsp_seq_number = rsp_seq_ff;
   assign rsp_bad_count  = rsp_bad_ff;

`ifndef SYNTHESIS
   a_not_last_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> !rsp_ok_ff && rsp_seq_ff == 16'h0)
      else $error("non-final item carries verdict or sequence");

   a_bad_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> bad_ff >= $past(bad_ff))
      else $error("bad-frame count decreased");

   a_hdr_count: assert property (@(posedge clock) disable iff (reset)
      sync_ff != SYNC_BODY |-> cnt_ff <= CNT_W'(1))
      else $error("byte counter out of range outside frame body");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      sync_ff == SYNC_BODY |-> cnt_ff >= CNT_W'(2) && cnt_ff <= CNT_W'(FRAME_END - 1))
      else $error("byte counter out of range in frame body");
`endif

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the framed receiver with a directed table of sync-hunt cases and
// then with random frames. The random frames have good or corrupted CRCs and
// are mixed with noise and broken headers. Both channels idle at random. Every
// result is checked field by field against the table's expected item or a
// byte-level model of the deframer kept in this file.
// ----------------------------------------------------------------------------
module testbench
   import shcdf_pkg::*;
();

   localparam int PAYLOAD_LEN   = PAYLOAD_LEN_DEF;
   localparam int DATA_END      = 4 + PAYLOAD_LEN;
   localparam int FRAME_LEN     = 8 + PAYLOAD_LEN;
   localparam int RANDOM_ITEMS  = 900;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int DIRECTED_ROWS = 17;

   typedef struct packed {
      logic [7:0]  data;
      logic [6:0]  index;
      logic        last;
      logic        ok;
      logic [15:0] seq;
      logic [15:0] bad;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]   rx;
      logic         typed;
      rsp_item_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic [6:0]  rsp_byte_index;
   logic        rsp_last;
   logic        rsp_frame_ok;
   logic [15:0] rsp_seq_number;
   logic [15:0] rsp_bad_count;

   // deframer model state
   sync_state_type rx_state;
   int             frame_pos;
   logic [31:0]    crc_acc;
   logic [15:0]    seq_hold;
   logic [31:0]    crc_rx;
   logic [15:0]    bad_frames;

   rsp_item_type expected_rsp[$];
   logic [7:0]   tx_bytes[$];

   int fail_count = 0;
   int sent_items = 0;
   int checked_rsp = 0;
   int good_seen = 0;
   int bad_seen = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_tick = 0;

   // sync hunt with the repeated and broken header cases; the typed rows
   // follow the header and check the sequence and payload byte positions
   row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b0, '0},
      '{8'h55, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h7E, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h55, 1'b0, '0},
      '{8'h00, 1'b1, '{8'h00, 7'd2, 1'b0, 1'b0, 16'h0000, 16'h0000}},
      '{8'hFF, 1'b1, '{8'hFF, 7'd3, 1'b0, 1'b0, 16'h0000, 16'h0000}},
      '{8'hAA, 1'b1, '{8'hAA, 7'd4, 1'b0, 1'b0, 16'h0000, 16'h0000}},
      '{8'h55, 1'b1, '{8'h55, 7'd5, 1'b0, 1'b0, 16'h0000, 16'h0000}},
      '{8'h01, 1'b1, '{8'h01, 7'd6, 1'b0, 1'b0, 16'h0000, 16'h0000}},
      '{8'h80, 1'b1, '{8'h80, 7'd7, 1'b0, 1'b0, 16'h0000, 16'h0000}}
   };

   sync_header_crc32_deframer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last       (rsp_last),
      .rsp_frame_ok   (rsp_frame_ok),
      .rsp_seq_number (rsp_seq_number),
      .rsp_bad_count  (rsp_bad_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'h000000, b};
      repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      return c;
   endfunction

   task automatic open_frame();
      crc_acc = crc32_update(CRC_ONES, SYNC_FIRST);
      frame_pos = 1;
      rx_state = SYNC_WAIT_H2;
   endtask

   task automatic deframe_byte(input logic [7:0] b, output bit has, output rsp_item_type r);
      int pos;
      has = 1'b0;
      r = '0;
      case (rx_state)
         SYNC_HUNT: begin
            if (b == SYNC_FIRST) open_frame();
         end
         SYNC_WAIT_H2: begin
            if (b == SYNC_SECOND) begin
               crc_acc = crc32_update(crc_acc, b);
               frame_pos = 2;
               rx_state = SYNC_BODY;
            end else if (b == SYNC_FIRST) begin
               open_frame();
            end else begin
               rx_state = SYNC_HUNT;
               frame_pos = 0;
               crc_acc = CRC_ONES;
            end
         end
         default: begin
            pos = frame_pos;
            if (pos < DATA_END) crc_acc = crc32_update(crc_acc, b);
            if (pos == 2) seq_hold[7:0] = b;
            else if (pos == 3) seq_hold[15:8] = b;
            else if (pos >= DATA_END) crc_rx = {b, crc_rx[31:8]};
            r.data = b;
            r.index = pos[6:0];
            if (pos + 1 >= FRAME_LEN) begin
               r.last = 1'b1;
               r.ok = (crc_rx == ~crc_acc);
               if (!r.ok && bad_frames != COUNT_MAX) bad_frames = bad_frames + 16'd1;
               r.seq = seq_hold;
               rx_state = SYNC_HUNT;
               frame_pos = 0;
               crc_acc = CRC_ONES;
            end else begin
               frame_pos = pos + 1;
            end
            r.bad = bad_frames;
            has = 1'b1;
         end
      endcase
   endtask

   // finishes an open frame, or appends noise, a broken header or a whole frame
   task automatic queue_frame();
      logic [7:0]  frm[$];
      logic [7:0]  b;
      logic [15:0] seq;
      logic [31:0] crc;
      int          kind;
      int          fill;
      int          n;
      kind = $urandom_range(0, 99);
      if (rx_state == SYNC_BODY) begin
         repeat (FRAME_LEN - frame_pos) tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
      end else if (kind < 10) begin
         n = $urandom_range(1, 12);
         repeat (n) tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
      end else if (kind < 20) begin
         tx_bytes = {tx_bytes, SYNC_FIRST};
         if ($urandom_range(0, 1) == 1) tx_bytes = {tx_bytes, SYNC_FIRST};
         b = 8'($urandom_range(0, 255));
         if (b == SYNC_FIRST || b == SYNC_SECOND) b = 8'h00;
         tx_bytes = {tx_bytes, b};
      end else begin
         n = $urandom_range(0, 3);
         repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == SYNC_FIRST) b = 8'h3C;
            tx_bytes = {tx_bytes, b};
         end
         if ($urandom_range(0, 3) == 0) tx_bytes = {tx_bytes, SYNC_FIRST};
         case ($urandom_range(0, 9))
            0: seq = 16'h0000;
            1: seq = 16'hFFFF;
            default: seq = 16'($urandom_range(0, 65535));
         endcase
         frm = {frm, SYNC_FIRST};
         frm = {frm, SYNC_SECOND};
         frm = {frm, seq[7:0]};
         frm = {frm, seq[15:8]};
         fill = $urandom_range(0, 9);
         repeat (PAYLOAD_LEN) begin
            if (fill == 0) frm = {frm, 8'h00};
            else if (fill == 1) frm = {frm, 8'hFF};
            else frm = {frm, 8'($urandom_range(0, 255))};
         end
         crc = CRC_ONES;
         foreach (frm[i]) crc = crc32_update(crc, frm[i]);
         crc = ~crc;
         for (int k = 0; k < 4; k++) frm = {frm, crc[8*k +: 8]};
         if ($urandom_range(0, 9) < 3) begin
            n = $urandom_range(2, FRAME_LEN - 1);
            frm[n] = frm[n] ^ (8'h01 << $urandom_range(0, 7));
         end
         foreach (frm[i]) tx_bytes = {tx_bytes, frm[i]};
      end
   endtask

   task automatic drive_byte(input logic [7:0] b, input bit typed, input rsp_item_type want,
                             output bit has);
      rsp_item_type r;
      req_rx_byte <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      deframe_byte(b, has, r);
      if (has) expected_rsp = {expected_rsp, typed ? want : r};
      sent_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   task automatic report_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field_name, want, got);
         fail_count++;
      end
   endtask

   // result channel: check, then pick the next ready from the stall pattern
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected item, actual data 0x%0h index %0d",
                        $time, rsp_data_byte, rsp_byte_index);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               report_field("data_byte", 32'(want.data), 32'(rsp_data_byte));
               report_field("byte_index", 32'(want.index), 32'(rsp_byte_index));
               report_field("last", 32'(want.last), 32'(rsp_last));
               report_field("frame_ok", 32'(want.ok), 32'(rsp_frame_ok));
               report_field("seq_number", 32'(want.seq), 32'(rsp_seq_number));
               report_field("bad_count", 32'(want.bad), 32'(rsp_bad_count));
               checked_rsp++;
               if (rsp_last && rsp_frame_ok) good_seen++;
               else if (rsp_last) bad_seen++;
            end
         end
         stall_tick++;
         case ((stall_tick / 256) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_tick % 16 < 10);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, %0d items still expected", $time, expected_rsp.size());
         $display("sync_header_crc32_deframer_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit         has;
      bit         paused_mid;
      int         random_rsp;
      logic [7:0] b;
      paused_mid = 1'b0;
      random_rsp = 0;
      rx_state = SYNC_HUNT;
      frame_pos = 0;
      crc_acc = CRC_ONES;
      seq_hold = 16'h0000;
      crc_rx = 32'h0000_0000;
      bad_frames = 16'h0000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want, has);
      end
      wait_results();

      while (sent_items < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (tx_bytes.size() == 0) queue_frame();
         b = tx_bytes.pop_front();
         drive_byte(b, 1'b0, '0, has);
         if (has) random_rsp++;
         if (!paused_mid && sent_items >= DIRECTED_ROWS + RANDOM_ITEMS / 2) begin
            wait_results();
            paused_mid = 1'b1;
         end
      end

      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drove %0d bytes (%0d from the table), checked %0d items (%0d random)",
               sent_items, DIRECTED_ROWS, checked_rsp, random_rsp);
      $display("Frames closed: %0d with matching CRC, %0d corrupted; noise mixed in",
               good_seen, bad_seen);
      if (fail_count == 0) begin
         $display("sync_header_crc32_deframer_top test passed");
      end else begin
         $display("sync_header_crc32_deframer_top test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/shcdf_pkg.sv
rtl/core/sync_header_crc32_deframer_top.sv
dv/testbench.sv
